// File: design/fupd_pkg.sv
// Shared types, constants and character helpers for the file URI decoder.
package fupd_pkg;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned MaxWords  = 7;

  localparam logic [1:0] MODE_PREFIX = 2'd0;
  localparam logic [1:0] MODE_PASS   = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  localparam logic [1:0] ESC_NONE    = 2'd0;
  localparam logic [1:0] ESC_PCT     = 2'd1;
  localparam logic [1:0] ESC_DIGIT   = 2'd2;

  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  // One result word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } word_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] pcnt;
    logic [1:0] esc;
    logic [7:0] held;
  } state_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h66; // f
      3'd1:    ch = 8'h69; // i
      3'd2:    ch = 8'h6c; // l
      3'd3:    ch = 8'h65; // e
      3'd4:    ch = 8'h3a; // :
      3'd5:    ch = 8'h2f; // /
      3'd6:    ch = 8'h2f; // /
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
    else v = b - 8'h37;
    return v[3:0];
  endfunction

endpackage

// File: design/fupd_step.sv
// Per-byte decode step: next state and the burst of result words for one byte.
module fupd_step (
  input  fupd_pkg::state_t st_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output fupd_pkg::state_t st_o,
  output fupd_pkg::word_t  words_o [fupd_pkg::MaxWords],
  output logic [2:0]       count_o
);
  import fupd_pkg::*;

  logic       plain;
  logic [2:0] c;
  logic [2:0] c1;
  logic [2:0] n;
  state_t     nx;
  word_t      w [MaxWords];

  always_comb begin
    nx    = st_i;
    n     = 3'd0;
    plain = 1'b0;
    for (int i = 0; i < MaxWords; i++) begin
      w[i] = '0;
    end
    c  = (st_i.pcnt > 3'd6) ? 3'd6 : st_i.pcnt;
    c1 = c + 3'd1;

    case (st_i.mode)
      MODE_PASS: begin
        w[n] = '{data: byte_i, last: last_i, empty: 1'b0};
        n    = n + 3'd1;
      end
      MODE_DECODE: begin
        case (st_i.esc)
          ESC_PCT: begin
            if (is_hex(byte_i)) begin
              if (last_i) begin
                w[0] = '{data: CH_PERCENT, last: 1'b0, empty: 1'b0};
                w[1] = '{data: byte_i, last: 1'b1, empty: 1'b0};
                n    = 3'd2;
              end else begin
                nx.held = byte_i;
                nx.esc  = ESC_DIGIT;
              end
            end else begin
              nx.esc = ESC_NONE;
              w[0]   = '{data: CH_PERCENT, last: 1'b0, empty: 1'b0};
              n      = 3'd1;
              plain  = 1'b1;
            end
          end
          ESC_DIGIT: begin
            nx.esc  = ESC_NONE;
            nx.held = '0;
            if (is_hex(byte_i)) begin
              w[0] = '{data: {hex_val(st_i.held), hex_val(byte_i)}, last: last_i,
                       empty: 1'b0};
              n    = 3'd1;
            end else begin
              w[0]  = '{data: CH_PERCENT, last: 1'b0, empty: 1'b0};
              w[1]  = '{data: st_i.held, last: 1'b0, empty: 1'b0};
              n     = 3'd2;
              plain = 1'b1;
            end
          end
          default: begin
            nx.esc = ESC_NONE;
            plain  = 1'b1;
          end
        endcase

        if (plain) begin
          if (byte_i == CH_PERCENT) begin
            if (last_i) begin
              w[n] = '{data: CH_PERCENT, last: 1'b1, empty: 1'b0};
              n    = n + 3'd1;
            end else begin
              nx.esc = ESC_PCT;
            end
          end else if (byte_i == CH_PLUS) begin
            w[n] = '{data: CH_SPACE, last: last_i, empty: 1'b0};
            n    = n + 3'd1;
          end else begin
            w[n] = '{data: byte_i, last: last_i, empty: 1'b0};
            n    = n + 3'd1;
          end
        end
      end
      default: begin
        // prefix check; the unused mode code behaves the same
        if (byte_i == prefix_char(c)) begin
          if (c1 == 3'(PrefixLen)) begin
            if (last_i) begin
              w[0] = '{data: 8'h00, last: 1'b1, empty: 1'b1};
              n    = 3'd1;
            end else begin
              nx.mode = MODE_DECODE;
              nx.pcnt = '0;
            end
          end else begin
            nx.pcnt = c1;
            if (last_i) begin
              // short URI that matched so far: replay it, last on the final one
              for (int i = 0; i < MaxWords; i++) begin
                if (3'(i) < c1) begin
                  w[i] = '{data: prefix_char(3'(i)), last: (3'(i) == c), empty: 1'b0};
                end
              end
              n = c1;
            end
          end
        end else begin
          for (int i = 0; i < MaxWords - 1; i++) begin
            if (3'(i) < c) begin
              w[i] = '{data: prefix_char(3'(i)), last: 1'b0, empty: 1'b0};
            end
          end
          w[c]    = '{data: byte_i, last: last_i, empty: 1'b0};
          n       = c1;
          nx.mode = MODE_PASS;
          nx.pcnt = '0;
        end
      end
    endcase

    if (last_i) begin
      nx = '{mode: MODE_PREFIX, pcnt: 3'd0, esc: ESC_NONE, held: 8'h00};
    end
  end

  assign st_o    = nx;
  assign words_o = w;
  assign count_o = n;

endmodule

// File: design/file_uri_percent_decoder.sv
// Top level of the file URI percent decoder: state, burst buffer and output register.
// Takes a URI one byte per word (tlast on the final byte). A leading "file://" is
// stripped and the rest percent-decoded ('+' to space, %XY to one byte, broken escapes
// kept literally); any other URI passes through unchanged. An input of exactly
// "file://" gives one word with tuser (empty) set. Each byte yields 0 to 7 words,
// which are queued in a seven-word burst buffer and drained one per clock through a
// registered output while it is not stalled. A byte making more than one word holds
// off input until the last word of its burst moves to the output register, so the
// block takes one byte per clock while each byte makes at most one word and the output
// is not stalled. A prefix mismatch after six matched bytes gives the most, seven words.
module file_uri_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // out_last
  output logic       m_axis_tuser    // [0] out_empty
);
  import fupd_pkg::*;

  state_t     st_q, st_d, st_nx;
  word_t      step_words [MaxWords];
  logic [2:0] step_cnt;
  word_t      buf_q [MaxWords];
  word_t      buf_d [MaxWords];
  logic [2:0] cnt_q, cnt_d;
  word_t      out_q, out_d;
  logic       ov_q, ov_d;
  logic       pop, accept;

  fupd_step u_step (
    .st_i    (st_q),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .st_o    (st_nx),
    .words_o (step_words),
    .count_o (step_cnt)
  );

  assign pop           = (cnt_q != 3'd0) && (!ov_q || m_axis_tready);
  assign s_axis_tready = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && pop);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d  = accept ? st_nx : st_q;
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (accept) begin
      buf_d = step_words;
      cnt_d = step_cnt;
    end else if (pop) begin
      for (int i = 0; i < MaxWords - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end

    out_d = out_q;
    ov_d  = ov_q;
    if (pop) begin
      out_d = buf_q[0];
      ov_d  = 1'b1;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{mode: MODE_PREFIX, pcnt: 3'd0, esc: ESC_NONE, held: 8'h00};
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.empty;

endmodule

// File: design/fupd_checker.sv
// Port-level checks for the file URI decoder, bound to the top level.
module fupd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // an empty-path word is always the end of its URI and carries no byte
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
    else $error("empty word without last or with data");

  // input is only held off while words are queued, so output is busy next cycle
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> m_axis_tvalid)
    else $error("input stalled with nothing to drain");

endmodule

bind file_uri_percent_decoder fupd_checker u_fupd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: dv/tb_file_uri_percent_decoder.sv
// Self-checking testbench for the file URI percent decoder: directed table plus random URIs.
`timescale 1ns / 1ps

module tb_file_uri_percent_decoder;
  import fupd_pkg::*;

  localparam logic [55:0] SCHEME = "file://";
  localparam int PhaseItems = 36;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    word_t      w;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;   // out_last
  logic       m_axis_tuser;   // [0] out_empty

  // expected path words, oldest first
  word_t path_q[$];
  int    mismatches = 0;
  int    src_idle   = 0;
  int    sink_stall = 0;
  int    sent_cnt   = 0;

  // predictor state
  logic [1:0] p_mode;
  logic [2:0] p_matched;
  logic [1:0] p_esc;
  logic [7:0] p_held;

  // Directed words: only the bare-scheme, top-byte and '+' rows carry a typed result.
  dir_row_t dir_tab [25] = '{
    '{"f", 1'b0, 1'b0, '0}, '{"i", 1'b0, 1'b0, '0}, '{"l", 1'b0, 1'b0, '0},
    '{"e", 1'b0, 1'b0, '0}, '{":", 1'b0, 1'b0, '0}, '{"/", 1'b0, 1'b0, '0},
    '{"/", 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},            // bare scheme: empty marker
    '{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b0}},          // top byte, one-word URI
    '{"f", 1'b0, 1'b0, '0}, '{"i", 1'b1, 1'b0, '0},      // short URI, prefix replayed
    '{"f", 1'b0, 1'b0, '0}, '{"i", 1'b0, 1'b0, '0}, '{"l", 1'b0, 1'b0, '0},
    '{"e", 1'b0, 1'b0, '0}, '{":", 1'b0, 1'b0, '0}, '{"/", 1'b0, 1'b0, '0},
    '{"/", 1'b0, 1'b0, '0},
    '{"%", 1'b0, 1'b0, '0}, '{"4", 1'b0, 1'b0, '0}, '{"1", 1'b0, 1'b0, '0},
    '{"+", 1'b0, 1'b1, '{CH_SPACE, 1'b0, 1'b0}},
    '{"%", 1'b0, 1'b0, '0}, '{"a", 1'b0, 1'b0, '0}, '{"G", 1'b0, 1'b0, '0},
    '{"%", 1'b1, 1'b0, '0}                               // escape cut by the end
  };

  file_uri_percent_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] scheme_char(input int i);
    return SCHEME[55 - 8 * i -: 8];
  endfunction

  function automatic bit hex_digit(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // letters of either case share the low nibble, offset by nine
  function automatic logic [3:0] nibble(input logic [7:0] b);
    return (b <= "9") ? b[3:0] : b[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  task automatic emit(input logic [7:0] d, input logic l, input logic e);
    path_q.push_back('{d, l, e});
  endtask

  task automatic literal(input logic [7:0] b, input logic l);
    if (b == CH_PERCENT) begin
      if (l) emit(CH_PERCENT, 1'b1, 1'b0);
      else p_esc = ESC_PCT;
    end else if (b == CH_PLUS) begin
      emit(CH_SPACE, l, 1'b0);
    end else begin
      emit(b, l, 1'b0);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic l);
    if (p_esc == ESC_PCT) begin
      if (hex_digit(b)) begin
        if (l) begin
          emit(CH_PERCENT, 1'b0, 1'b0);
          emit(b, 1'b1, 1'b0);
        end else begin
          p_held = b;
          p_esc  = ESC_DIGIT;
        end
      end else begin
        p_esc = ESC_NONE;
        emit(CH_PERCENT, 1'b0, 1'b0);
        literal(b, l);
      end
    end else if (p_esc == ESC_DIGIT) begin
      p_esc = ESC_NONE;
      if (hex_digit(b)) begin
        emit({nibble(p_held), nibble(b)}, l, 1'b0);
      end else begin
        emit(CH_PERCENT, 1'b0, 1'b0);
        emit(p_held, 1'b0, 1'b0);
        literal(b, l);
      end
      p_held = 8'h00;
    end else begin
      p_esc = ESC_NONE;
      literal(b, l);
    end
  endtask

  task automatic prefix_byte(input logic [7:0] b, input logic l);
    int c;
    c = (p_matched > 3'd6) ? 6 : int'(p_matched);
    if (b == scheme_char(c)) begin
      c++;
      if (c == PrefixLen) begin
        if (l) emit(8'h00, 1'b1, 1'b1);
        else begin
          p_mode    = MODE_DECODE;
          p_matched = '0;
        end
      end else begin
        p_matched = 3'(c);
        if (l)
          for (int i = 0; i < c; i++) emit(scheme_char(i), i + 1 == c, 1'b0);
      end
    end else begin
      for (int i = 0; i < c; i++) emit(scheme_char(i), 1'b0, 1'b0);
      emit(b, l, 1'b0);
      p_mode    = MODE_PASS;
      p_matched = '0;
    end
  endtask

  task automatic predict_path(input logic [7:0] b, input logic l);
    case (p_mode)
      MODE_PASS:   emit(b, l, 1'b0);
      MODE_DECODE: decode_byte(b, l);
      default:     prefix_byte(b, l);
    endcase
    if (l) begin
      p_mode    = MODE_PREFIX;
      p_matched = '0;
      p_esc     = ESC_NONE;
      p_held    = 8'h00;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns  mismatch: %s", $realtime, msg);
  endtask

  // Entered and left at a falling edge; predicts once the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input word_t w);
    int n;
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = path_q.size();
    predict_path(b, l);
    if (typed) begin
      while (path_q.size() > n) void'(path_q.pop_back());
      path_q.push_back(w);
    end
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_random_uri();
    logic [7:0] uri[$];
    int kind, n, k;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // well-formed file URI with an escape-heavy body
      for (int i = 0; i < PrefixLen; i++) uri.push_back(scheme_char(i));
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 99);
        if (k < 25) begin
          uri.push_back(CH_PERCENT);
          if ($urandom_range(0, 7) == 0) begin
            uri.push_back("0");
            uri.push_back("0");
          end else begin
            uri.push_back(rand_hex());
            uri.push_back(rand_hex());
          end
        end else if (k < 35) uri.push_back(CH_PLUS);
        else if (k < 45) uri.push_back(rand_hex());
        else if (k < 55) uri.push_back(CH_PERCENT);
        else uri.push_back(8'($urandom_range(1, 255)));
      end
    end else if (kind < 80) begin
      // partial scheme, possibly broken on its last byte
      n = $urandom_range(1, PrefixLen);
      for (int i = 0; i < n; i++) uri.push_back(scheme_char(i));
      if ($urandom_range(0, 1)) uri[n - 1] = 8'($urandom_range(1, 255));
      k = $urandom_range(0, 4);
      for (int i = 0; i < k; i++) uri.push_back(8'($urandom_range(1, 255)));
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) uri.push_back(8'($urandom_range(1, 255)));
    end
    foreach (uri[i]) send_byte(uri[i], i == uri.size() - 1, 1'b0, '0);
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);

  always @(posedge clk_i) begin
    word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (path_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%02h last=%b empty=%b",
                                  m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        exp_w = path_q.pop_front();
        // data is don't-care on the empty marker
        if (!exp_w.empty && m_axis_tdata !== exp_w.data)
          report_mismatch($sformatf("data %02h, expected %02h", m_axis_tdata, exp_w.data));
        if (m_axis_tlast !== exp_w.last)
          report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, exp_w.last));
        if (m_axis_tuser !== exp_w.empty)
          report_mismatch($sformatf("tuser %b, expected %b", m_axis_tuser, exp_w.empty));
      end
    end
  end

  initial begin
    int src_tab [4];
    int sink_tab [4];
    src_tab  = '{0, 78, 0, 29};
    sink_tab = '{0, 0, 78, 29};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    p_mode        = MODE_PREFIX;
    p_matched     = '0;
    p_esc         = ESC_NONE;
    p_held        = 8'h00;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].w);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle   = src_tab[ph];
      sink_stall = sink_tab[ph];
      sent_cnt   = 0;
      while (sent_cnt < PhaseItems) send_random_uri();
      // hold the input off until the block has drained
      s_axis_tvalid <= 1'b0;
      while (path_q.size() != 0) @(negedge clk_i);
    end

    sink_stall = 0;
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && path_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: file_uri_percent_decoder.f
design/fupd_pkg.sv
design/fupd_step.sv
design/file_uri_percent_decoder.sv
design/fupd_checker.sv
dv/tb_file_uri_percent_decoder.sv
